>>> rtl/q2e_pkg.sv
// shared widths, constants and the arctangent table for the quaternion to euler block
`default_nettype none
package q2e_pkg;

    localparam int PROD_W      = 32;
    localparam int MW          = 35;
    localparam int SW          = 32;
    localparam int SABS_W      = 31;
    localparam int RAD_W       = 61;
    localparam int SQRT_DIGITS = 31;
    localparam int ROOT_W      = 31;
    localparam int REM_W       = 33;
    localparam int XW          = 38;
    localparam int ZW          = 34;
    localparam int AW          = ZW - 16;
    localparam int ATAN_W      = 28;
    localparam int ANG_LEN     = 24;
    localparam int DECL_W      = 15;
    localparam int YAW_W       = 15;
    localparam int PITCH_W     = 14;
    localparam int ROLL_W      = 15;
    localparam int DIFF_W      = 17;

    localparam logic signed [ZW-1:0]     ANG_HALF   = ZW'(180 * (2 ** 22));
    localparam logic signed [ZW-1:0]     ROUND_HALF = ZW'(2 ** 15);
    localparam logic signed [AW-1:0]     ROLL_LIM   = AW'(11520);
    localparam logic signed [AW:0]       PITCH_LIM  = (AW + 1)'(5760);
    localparam logic signed [DIFF_W-1:0] FULL_TURN  = DIFF_W'(23040);
    localparam logic signed [DIFF_W-1:0] TWO_TURNS  = DIFF_W'(46080);
    localparam logic [DECL_W-1:0]        DECL_RESET = DECL_W'(126);
    localparam logic [RAD_W-1:0]         ONE_SQ     = RAD_W'(1) << 60;

    function automatic logic [ATAN_W-1:0] atan_val(input int idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = ATAN_W'(188743680);
            1:       v = ATAN_W'(111421900);
            2:       v = ATAN_W'(58872272);
            3:       v = ATAN_W'(29884485);
            4:       v = ATAN_W'(15000234);
            5:       v = ATAN_W'(7507429);
            6:       v = ATAN_W'(3754631);
            7:       v = ATAN_W'(1877430);
            8:       v = ATAN_W'(938729);
            9:       v = ATAN_W'(469366);
            10:      v = ATAN_W'(234683);
            11:      v = ATAN_W'(117342);
            12:      v = ATAN_W'(58671);
            13:      v = ATAN_W'(29335);
            14:      v = ATAN_W'(14668);
            15:      v = ATAN_W'(7334);
            16:      v = ATAN_W'(3667);
            17:      v = ATAN_W'(1833);
            18:      v = ATAN_W'(917);
            19:      v = ATAN_W'(458);
            20:      v = ATAN_W'(229);
            21:      v = ATAN_W'(115);
            22:      v = ATAN_W'(57);
            23:      v = ATAN_W'(29);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/q2e_delay.sv
// enabled shift line that carries side data alongside the square root pipeline
`default_nettype none
module q2e_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_data,
    output logic      [W-1:0] o_data
);
    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];
endmodule
`default_nettype wire

>>> rtl/q2e_isqrt.sv
// pipelined restoring integer square root, one root bit per stage
`default_nettype none
module q2e_isqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [q2e_pkg::RAD_W-1:0]    i_rad,
    output logic                              o_valid,
    output logic      [q2e_pkg::ROOT_W-1:0]   o_root
);
    import q2e_pkg::*;

    logic [REM_W-1:0]         c_rem  [0:SQRT_DIGITS];
    logic [ROOT_W-1:0]        c_root [0:SQRT_DIGITS];
    logic [2*SQRT_DIGITS-1:0] c_rad  [0:SQRT_DIGITS-1];
    logic                     c_v    [0:SQRT_DIGITS];

    assign c_rem[0]  = '0;
    assign c_root[0] = '0;
    assign c_rad[0]  = (2*SQRT_DIGITS)'(i_rad);
    assign c_v[0]    = i_valid;

    for (genvar k = 0; k < SQRT_DIGITS; k++) begin : g_digit
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic              r_v;

        assign cur   = {c_rem[k], c_rad[k][2*SQRT_DIGITS-1 -: 2]};
        assign trial = {2'b00, c_root[k], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                r_root <= {c_root[k][ROOT_W-2:0], ge};
            end
        end

        if (k < SQRT_DIGITS - 1) begin : g_rad
            logic [2*SQRT_DIGITS-1:0] r_rad;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad <= c_rad[k] << 2;
                end
            end
            assign c_rad[k+1] = r_rad;
        end

        assign c_rem[k+1]  = r_rem;
        assign c_root[k+1] = r_root;
        assign c_v[k+1]    = r_v;
    end

    assign o_valid = c_v[SQRT_DIGITS];
    assign o_root  = c_root[SQRT_DIGITS];
endmodule
`default_nettype wire

>>> rtl/q2e_cordic.sv
// pipelined vectoring cordic: two-argument arctangent rounded to 1/64 degree
`default_nettype none
module q2e_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic signed [q2e_pkg::XW-1:0]     i_x,
    input  wire logic signed [q2e_pkg::XW-1:0]     i_y,
    output logic                                   o_valid,
    output logic signed      [q2e_pkg::AW-1:0]     o_angle
);
    import q2e_pkg::*;

    logic signed [XW-1:0] c_x    [0:STAGES-1];
    logic signed [XW-1:0] c_y    [0:STAGES-1];
    logic signed [ZW-1:0] c_z    [0:STAGES];
    logic                 c_zero [0:STAGES];
    logic                 c_v    [0:STAGES];

    logic signed [XW-1:0] r_px;
    logic signed [XW-1:0] r_py;
    logic signed [ZW-1:0] r_pz;
    logic                 r_pzero;
    logic                 r_pv;
    logic                 neg;
    logic signed [ZW-1:0] n_pz;
    logic signed [ZW-1:0] z_rnd;
    logic signed [AW-1:0] r_ang;
    logic                 r_ov;

    assign neg  = i_x[XW-1];
    assign n_pz = !neg ? '0 : (!i_y[XW-1] ? ANG_HALF : -ANG_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= neg ? -i_x : i_x;
            r_py    <= neg ? -i_y : i_y;
            r_pz    <= n_pz;
            r_pzero <= (i_x == '0) && (i_y == '0);
        end
    end

    assign c_x[0]    = r_px;
    assign c_y[0]    = r_py;
    assign c_z[0]    = r_pz;
    assign c_zero[0] = r_pzero;
    assign c_v[0]    = r_pv;

    for (genvar k = 0; k < STAGES; k++) begin : g_iter
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] ang;
        logic                 up;
        logic signed [ZW-1:0] r_z;
        logic                 r_zero;
        logic                 r_v;

        assign xs  = c_x[k] >>> k;
        assign ys  = c_y[k] >>> k;
        assign ang = ZW'(atan_val(k));
        assign up  = !c_y[k][XW-1] && (c_y[k] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z    <= up ? c_z[k] + ang : c_z[k] - ang;
                r_zero <= c_zero[k];
            end
        end

        if (k < STAGES - 1) begin : g_xy
            logic signed [XW-1:0] r_x;
            logic signed [XW-1:0] r_y;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x <= up ? c_x[k] + ys : c_x[k] - ys;
                    r_y <= up ? c_y[k] - xs : c_y[k] + xs;
                end
            end
            assign c_x[k+1] = r_x;
            assign c_y[k+1] = r_y;
        end

        assign c_z[k+1]    = r_z;
        assign c_zero[k+1] = r_zero;
        assign c_v[k+1]    = r_v;
    end

    assign z_rnd = c_z[STAGES] + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= c_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= c_zero[STAGES] ? '0 : z_rnd[ZW-1:16];
        end
    end

    assign o_valid = r_ov;
    assign o_angle = r_ang;
endmodule
`default_nettype wire

>>> rtl/quaternion_to_euler_angles.sv
// top level: quaternion to zyx euler angles, fully pipelined
//
// channel   dir  beat                       fields (lowest bit up)
// s_axis    in   one quaternion             quat_w, quat_x, quat_y, quat_z
// m_axis    out  one set of angles          yaw_angle, pitch_angle, roll_angle
// cfg       in   declination_offset write   declination_offset
//
// one beat accepted per cycle while the output is not held; the pipeline is made of
// three product/term stages, the 31-stage square root, the cordic
// (CORDIC_STAGES + 2) and two output stages
// synchronous active-low reset clears valid bits and sets declination to 126
// a held output beat stalls the whole pipeline; nothing is dropped or repeated
`default_nettype none
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES  = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [63:0]                       i_s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic      [47:0]                       o_m_axis_tdata,  // yaw, pitch, roll, zero pad
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [q2e_pkg::DECL_W-1:0]        i_cfg_data       // declination_offset
);
    import q2e_pkg::*;

    localparam int FRAC = 2 * QUAT_FRAC_BITS;
    localparam int SHL  = (FRAC < 30) ? 30 - FRAC : 0;
    localparam int SHR  = (FRAC >= 30) ? FRAC - 30 : 0;
    localparam int DLY_W = SW + 4 * MW;
    localparam logic signed [63:0] S_ONE = 64'sd1 <<< 30;

    logic en;
    logic [DECL_W-1:0] r_decl;

    logic signed [15:0] qw, qx, qy, qz;
    logic r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_wx, r_yz, r_xz, r_wy;
    logic signed [MW-1:0] n_m32;
    logic signed [MW-1:0] r_m12, r_m22, r_m31, r_m33;
    logic signed [63:0]   s_w;
    logic signed [SW-1:0] n_s, r_s;
    logic [SABS_W-1:0]    s_abs;
    logic [RAD_W-1:0]     r_sq;

    logic                 w_sq_v;
    logic [ROOT_W-1:0]    w_root;
    logic [DLY_W-1:0]     w_dly;
    logic signed [SW-1:0] d_s;
    logic signed [MW-1:0] d_m12, d_m22, d_m31, d_m33;

    logic w_pitch_v, w_roll_v, w_yaw_v;
    logic signed [AW-1:0] w_pitch_a, w_roll_a, w_yaw_a;

    logic signed [AW:0]          neg_p;
    logic signed [ROLL_W-1:0]    yaw_c;
    logic r_v5, r_ov;
    logic signed [PITCH_W-1:0]   r_pitch, r_pitch_o;
    logic signed [ROLL_W-1:0]    r_roll, r_roll_o;
    logic signed [DIFF_W-1:0]    r_diff, n_wrap;
    logic [YAW_W-1:0]            r_yaw_o;

    assign en              = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
        end else if (i_cfg_valid) begin
            r_decl <= i_cfg_data;
        end
    end

    assign qw = i_s_axis_tdata[15:0];
    assign qx = i_s_axis_tdata[31:16];
    assign qy = i_s_axis_tdata[47:32];
    assign qz = i_s_axis_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v5 <= w_pitch_v;
            r_ov <= r_v5;
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= qw * qw;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_zz <= qz * qz;
            r_xy <= qx * qy;
            r_wz <= qw * qz;
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xz <= qx * qz;
            r_wy <= qw * qy;
        end
    end

    // matrix terms and scaled, saturated arcsine argument
    assign n_m32 = (MW'(r_xz) - MW'(r_wy)) <<< 1;
    assign s_w   = (64'(n_m32) <<< SHL) >>> SHR;
    assign n_s   = (s_w > S_ONE) ? SW'(S_ONE) : (s_w < -S_ONE) ? SW'(-S_ONE) : SW'(s_w);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m12 <= (MW'(r_xy) + MW'(r_wz)) <<< 1;
            r_m22 <= MW'(r_ww) + MW'(r_xx) - MW'(r_yy) - MW'(r_zz);
            r_m31 <= (MW'(r_wx) + MW'(r_yz)) <<< 1;
            r_m33 <= MW'(r_ww) - MW'(r_xx) - MW'(r_yy) + MW'(r_zz);
            r_s   <= n_s;
        end
    end

    assign s_abs = r_s[SW-1] ? SABS_W'(-r_s) : SABS_W'(r_s);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq <= RAD_W'(s_abs * s_abs);
        end
    end

    q2e_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_rad   (ONE_SQ - r_sq),
        .o_valid (w_sq_v),
        .o_root  (w_root)
    );

    q2e_delay #(
        .W     (DLY_W),
        .DEPTH (SQRT_DIGITS + 1)
    ) u_delay (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_s, r_m12, r_m22, r_m31, r_m33}),
        .o_data (w_dly)
    );

    assign {d_s, d_m12, d_m22, d_m31, d_m33} = w_dly;

    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_sq_v),
        .i_x     (XW'(signed'({1'b0, w_root}))),
        .i_y     (XW'(d_s)),
        .o_valid (w_pitch_v),
        .o_angle (w_pitch_a)
    );

    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_sq_v),
        .i_x     (XW'(d_m33)),
        .i_y     (XW'(d_m31)),
        .o_valid (w_roll_v),
        .o_angle (w_roll_a)
    );

    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_sq_v),
        .i_x     (XW'(d_m22)),
        .i_y     (XW'(d_m12)),
        .o_valid (w_yaw_v),
        .o_angle (w_yaw_a)
    );

    // clamp, negate pitch, subtract declination
    assign neg_p = -((AW + 1)'(w_pitch_a));
    assign yaw_c = (w_yaw_a > ROLL_LIM) ? ROLL_W'(ROLL_LIM) :
                   (w_yaw_a < -ROLL_LIM) ? ROLL_W'(-ROLL_LIM) : ROLL_W'(w_yaw_a);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch <= (neg_p > PITCH_LIM) ? PITCH_W'(PITCH_LIM) :
                       (neg_p < -PITCH_LIM) ? PITCH_W'(-PITCH_LIM) : PITCH_W'(neg_p);
            r_roll  <= (w_roll_a > ROLL_LIM) ? ROLL_W'(ROLL_LIM) :
                       (w_roll_a < -ROLL_LIM) ? ROLL_W'(-ROLL_LIM) : ROLL_W'(w_roll_a);
            r_diff  <= DIFF_W'(yaw_c) - DIFF_W'(signed'(r_decl));
        end
    end

    // wrap heading into one turn
    assign n_wrap = (r_diff < -FULL_TURN) ? r_diff + TWO_TURNS :
                    (r_diff < 0)          ? r_diff + FULL_TURN :
                    (r_diff >= FULL_TURN) ? r_diff - FULL_TURN : r_diff;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw_o   <= YAW_W'(n_wrap);
            r_pitch_o <= r_pitch;
            r_roll_o  <= r_roll;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {4'b0000, r_roll_o, r_pitch_o, r_yaw_o};

`ifndef SYNTHESIS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pitch_v == w_roll_v) && (w_pitch_v == w_yaw_v))
        else $error("cordic lanes out of step");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:0] < 15'd23040))
        else $error("yaw beat outside one turn");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pitch_o <= 14'sd5760) && (r_pitch_o >= -14'sd5760))
        else $error("pitch beat outside limits");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_roll_o <= 15'sd11520) && (r_roll_o >= -15'sd11520))
        else $error("roll beat outside limits");
`endif
endmodule
`default_nettype wire

>>> tb/testbench.sv
// testbench for the quaternion to euler angles block: predicts angles and checks each output beat
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 54;
    localparam int STALL_LIMIT = 20000;
    localparam int NUM_RANDOM = 810;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } t_quat;

    typedef struct packed {
        logic [14:0] roll;
        logic [13:0] pitch;
        logic [14:0] yaw;
    } t_angles;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = '0;

    quaternion_to_euler_angles dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_quat   quat_pending[$];
    t_angles angles_expected[$];
    longint  declination = 126;
    int      errors = 0;
    int      beats_in = 0;
    int      beats_out = 0;
    int      idle_cycles = 0;
    bit      run_gaps = 1'b1;
    bit      hold_off = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;

    longint atan_deg[24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
        1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29
    };

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r = 0;
        longint b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint a = 0;
        longint xs, ys;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            a = (y >= 0) ? (64'sd180 <<< 22) : -(64'sd180 <<< 22);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                a = a + atan_deg[i];
            end else begin
                x = x - ys;
                y = y + xs;
                a = a - atan_deg[i];
            end
        end
        return a;
    endfunction

    function automatic longint to_sixtyfourths(longint a);
        return shr_floor(a + (64'sd1 <<< 15), 16);
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_angles predict_angles(t_quat q);
        longint w = q.w, x = q.x, y = q.y, z = q.z;
        longint m12, m22, m31, m32, m33, s, c, yaw;
        longint one = 64'sd1 <<< 30;
        t_angles r;
        m12 = 2 * (x * y + w * z);
        m22 = w * w + x * x - y * y - z * z;
        m31 = 2 * (w * x + y * z);
        m32 = 2 * (x * z - w * y);
        m33 = w * w - x * x - y * y + z * z;
        s = m32 * 4;
        if (s > one) s = one;
        if (s < -one) s = -one;
        c = int_sqrt(one * one - s * s);
        r.pitch = 14'(clamp(-to_sixtyfourths(vector_angle(s, c)), 5760));
        r.roll = 15'(clamp(to_sixtyfourths(vector_angle(m31, m33)), 11520));
        yaw = clamp(to_sixtyfourths(vector_angle(m12, m22)), 11520) - declination;
        yaw = yaw % 23040;
        if (yaw < 0) yaw = yaw + 23040;
        r.yaw = 15'(yaw);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            angles_expected.push_back(predict_angles(t_quat'(s_tdata)));
            beats_in++;
            void'(quat_pending.pop_front());
        end
        if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (quat_pending.size() > (s_tvalid && s_tready ? 0 : 0)) begin
            if (s_tvalid && s_tready) begin
                if (quat_pending.size() > 0) begin
                    if (run_gaps && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(1, 16);
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata <= quat_pending[0];
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= quat_pending[0];
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angles got, want;
        if (m_tvalid && m_tready) begin
            got = t_angles'(m_tdata[43:0]);
            if (angles_expected.size() == 0) begin
                $display("unexpected output beat %0d", beats_out);
                errors++;
            end else begin
                want = angles_expected.pop_front();
                if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
                if (got.pitch !== want.pitch)
                    report_mismatch("pitch", $signed(got.pitch), $signed(want.pitch));
                if (got.roll !== want.roll)
                    report_mismatch("roll", $signed(got.roll), $signed(want.roll));
            end
            beats_out++;
        end
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else if (run_gaps && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return 16'(int'($urandom_range(0, 32768)) - 16384);
            1: return 16'($urandom);
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    function automatic t_quat unit_quat();
        real a, b, c, d, n;
        t_quat q;
        a = real'(int'($urandom_range(0, 2000)) - 1000);
        b = real'(int'($urandom_range(0, 2000)) - 1000);
        c = real'(int'($urandom_range(0, 2000)) - 1000);
        d = real'(int'($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        q.w = 16'($rtoi(a / n * 16384.0));
        q.x = 16'($rtoi(b / n * 16384.0));
        q.y = 16'($rtoi(c / n * 16384.0));
        q.z = 16'($rtoi(d / n * 16384.0));
        return q;
    endfunction

    task automatic wait_drained();
        while (quat_pending.size() > 0 || s_tvalid || angles_expected.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_declination(logic signed [14:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        declination = v;
    endtask

    task automatic queue_quat(int w, int x, int y, int z);
        t_quat q;
        q.w = 16'(w);
        q.x = 16'(x);
        q.y = 16'(y);
        q.z = 16'(z);
        quat_pending.push_back(q);
    endtask

    initial begin
        int decl_set[6] = '{126, -11520, 11520, 0, -1, 5000};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, axes, extremes, zero vector, saturation, reset declination
        queue_quat(16384, 0, 0, 0);
        queue_quat(0, 0, 0, 0);
        queue_quat(-16384, 0, 0, 0);
        queue_quat(0, 16384, 0, 0);
        queue_quat(0, 0, 16384, 0);
        queue_quat(0, 0, 0, 16384);
        queue_quat(0, -16384, 0, 0);
        queue_quat(0, 0, -16384, 0);
        queue_quat(0, 0, 0, -16384);
        queue_quat(11585, 0, 11585, 0);
        queue_quat(11585, 0, -11585, 0);
        queue_quat(16384, 0, 16384, 0);
        queue_quat(16384, 0, -16384, 0);
        queue_quat(16384, 16384, 16384, 16384);
        queue_quat(-16384, -16384, -16384, -16384);
        queue_quat(-32768, -32768, 32767, 32767);
        queue_quat(32767, 32767, 32767, 32767);
        queue_quat(-32768, 32767, -32768, 32767);
        queue_quat(16384, -1, 0, 0);
        queue_quat(0, 16384, 1, 0);
        queue_quat(1, 0, 0, -1);
        queue_quat(-1, 0, 0, 1);
        queue_quat(8192, 8192, -8192, 8192);
        queue_quat(0, 0, 11585, -11585);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            write_declination(15'(decl_set[phase]));
            if (phase == 2) begin
                hold_off = 1'b1;
                for (int i = 0; i < 120; i++) quat_pending.push_back(unit_quat());
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            if (phase == 5) run_gaps = 1'b0;
            for (int i = 0; i < NUM_RANDOM / 6; i++) begin
                t_quat q;
                if ($urandom_range(0, 3) != 0) begin
                    q = unit_quat();
                end else begin
                    q.w = rand_comp();
                    q.x = rand_comp();
                    q.y = rand_comp();
                    q.z = rand_comp();
                end
                quat_pending.push_back(q);
            end
            wait_drained();
        end

        $display("covered %0d input beats and %0d output beats over 7 declination settings",
                 beats_in, beats_out);
        $display("including axis, extreme, zero and saturating quaternions and a long output stall");
        if (errors == 0 && angles_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
